@@ rtl/hlv_pkg.sv @@
package hlv_pkg;

   // Limits on the name and on each dot-separated label
   localparam int unsigned MAX_NAME_LENGTH  = 253;
   localparam int unsigned MAX_LABEL_LENGTH = 63;

   // Counters saturate one past their limit
   localparam int unsigned TOTAL_W = $clog2(MAX_NAME_LENGTH + 2);
   localparam int unsigned LABEL_W = $clog2(MAX_LABEL_LENGTH + 2);

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_NAME_LENGTH);
   localparam logic [LABEL_W-1:0] LABEL_MAX = LABEL_W'(MAX_LABEL_LENGTH);

   // Character codes with a special role
   localparam logic [7:0] CHAR_END    = 8'h00;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

   // Running state of the name being checked
   typedef struct packed {
      logic [TOTAL_W-1:0] total_length;
      logic [LABEL_W-1:0] label_length;
      logic               previous_was_hyphen;
      logic               name_failed;
   } hlv_state_type;

   localparam hlv_state_type STATE_CLEAR = '{
      total_length:        '0,
      label_length:        '0,
      previous_was_hyphen: 1'b0,
      name_failed:         1'b0
   };

   // ASCII letters and digits
   function automatic logic is_alnum(input logic [7:0] code);
      return code inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

endpackage

@@ rtl/hlv_req_if.sv @@
interface hlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

@@ rtl/hlv_rsp_if.sv @@
interface hlv_rsp_if;
   logic valid;
   logic ready;
   logic hostname_ok;

   modport source (output valid, output hostname_ok, input ready);
   modport sink   (input valid, input hostname_ok, output ready);
endinterface

@@ rtl/hostname_label_validator_top.sv @@
// Path: a terminator accepted into the input register is loaded into the result register
//   once that register is free; its verdict is offered from the result register.
// Throughput: one character per cycle, but a terminator waits while the result register
//   still holds a verdict; an input register and the result register let a new
//   character be taken while a verdict waits.
// Reset: synchronous, active high; clears both valid flags and the name state.
module hostname_label_validator_top (
   input logic       clock,
   input logic       reset,
   hlv_req_if.sink   req_chan,
   hlv_rsp_if.source rsp_chan
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   hlv_pkg::hlv_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff;
   logic                   ok_comb;
   logic                   out_free;
   logic                   advance;
   logic                   load_rsp;

   hlv_char_check u_check (
      .char_code   (in_char_ff),
      .state_cur   (state_ff),
      .state_next  (state_in),
      .hostname_ok (ok_comb)
   );

   // stage control: a terminator waits for room in the result register
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && ((in_char_ff != hlv_pkg::CHAR_END) || out_free);
   assign load_rsp       = advance && (in_char_ff == hlv_pkg::CHAR_END);
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= hlv_pkg::STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.char_code;
      end
      if (load_rsp) begin
         rsp_ok_ff <= ok_comb;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hostname_ok = rsp_ok_ff;

endmodule

@@ rtl/hlv_char_check.sv @@
module hlv_char_check (
   input  logic [7:0]             char_code,
   input  hlv_pkg::hlv_state_type state_cur,
   output hlv_pkg::hlv_state_type state_next,
   output logic                   hostname_ok
);

   logic [hlv_pkg::TOTAL_W-1:0] total_inc;
   logic [hlv_pkg::LABEL_W-1:0] label_inc;
   logic                        fail_acc;

   always_comb begin
      // saturating counters
      total_inc = (state_cur.total_length <= hlv_pkg::TOTAL_MAX) ?
                  state_cur.total_length + 1'b1 : state_cur.total_length;
      label_inc = (state_cur.label_length <= hlv_pkg::LABEL_MAX) ?
                  state_cur.label_length + 1'b1 : state_cur.label_length;

      // verdict on the terminator
      hostname_ok = !state_cur.name_failed &&
                    (state_cur.total_length != '0) &&
                    (state_cur.total_length <= hlv_pkg::TOTAL_MAX) &&
                    (state_cur.label_length != '0) &&
                    !state_cur.previous_was_hyphen;

      fail_acc   = state_cur.name_failed || (total_inc > hlv_pkg::TOTAL_MAX);
      state_next = state_cur;
      state_next.total_length = total_inc;

      if (char_code == hlv_pkg::CHAR_END) begin
         state_next = hlv_pkg::STATE_CLEAR;
      end else if (char_code == hlv_pkg::CHAR_DOT) begin
         // label boundary: label must be non-empty and not end in a hyphen
         state_next.name_failed = fail_acc || (state_cur.label_length == '0) ||
                                  state_cur.previous_was_hyphen;
         state_next.label_length        = '0;
         state_next.previous_was_hyphen = 1'b0;
      end else begin
         if (char_code == hlv_pkg::CHAR_HYPHEN) begin
            fail_acc = fail_acc || (state_cur.label_length == '0);
            state_next.previous_was_hyphen = 1'b1;
         end else begin
            fail_acc = fail_acc || !hlv_pkg::is_alnum(char_code);
            state_next.previous_was_hyphen = 1'b0;
         end
         state_next.label_length = label_inc;
         state_next.name_failed  = fail_acc || (label_inc > hlv_pkg::LABEL_MAX);
      end
   end

endmodule

@@ rtl/hlv_checker.sv @@
module hlv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_code,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_hostname_ok
);

   // verdict is held until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hostname_ok))
      else $error("rsp payload changed while stalled");

   // an accepted terminator gives a verdict through the input and result registers when rsp is not stalled
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_char_code == hlv_pkg::CHAR_END)) ##1 rsp_ready
      |=> rsp_valid)
      else $error("missing verdict after terminator");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind hostname_label_validator_top hlv_checker u_hlv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_char_code   (req_chan.char_code),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hostname_ok (rsp_chan.hostname_ok)
);

@@ test/hostname_label_validator_top_tb.sv @@
`timescale 1ns / 1ps

typedef logic [7:0] char_list_type[$];

// Tracks the name being sent and holds the verdicts still owed by the block
class hostname_verdict_board;
   logic [hlv_pkg::TOTAL_W-1:0] name_len;
   logic [hlv_pkg::LABEL_W-1:0] label_len;
   logic                        last_hyphen;
   logic                        broken;
   logic                        owed_verdicts[$];
   int                          mismatches;

   function new();
      clear_name();
      mismatches = 0;
   endfunction

   function void clear_name();
      name_len    = '0;
      label_len   = '0;
      last_hyphen = 1'b0;
      broken      = 1'b0;
   endfunction

   // Letters and digits only
   function bit is_letter_or_digit(logic [7:0] code);
      return (code >= 8'h30 && code <= 8'h39) || (code >= 8'h41 && code <= 8'h5A) ||
             (code >= 8'h61 && code <= 8'h7A);
   endfunction

   // Advance the name state by one accepted character
   function void note_char(logic [7:0] code);
      logic ok;
      if (code == hlv_pkg::CHAR_END) begin
         ok = !broken && name_len != 0 && name_len <= hlv_pkg::TOTAL_MAX &&
              label_len != 0 && !last_hyphen;
         owed_verdicts.push_back(ok);
         clear_name();
         return;
      end
      if (name_len <= hlv_pkg::TOTAL_MAX) name_len++;
      if (name_len > hlv_pkg::TOTAL_MAX) broken = 1'b1;
      if (code == hlv_pkg::CHAR_DOT) begin
         if (label_len == 0 || last_hyphen) broken = 1'b1;
         label_len   = '0;
         last_hyphen = 1'b0;
         return;
      end
      if (code == hlv_pkg::CHAR_HYPHEN) begin
         if (label_len == 0) broken = 1'b1;
         last_hyphen = 1'b1;
      end else begin
         if (!is_letter_or_digit(code)) broken = 1'b1;
         last_hyphen = 1'b0;
      end
      if (label_len <= hlv_pkg::LABEL_MAX) label_len++;
      if (label_len > hlv_pkg::LABEL_MAX) broken = 1'b1;
   endfunction

   // Compare one verdict transfer with the oldest owed verdict
   function void check_verdict(logic actual);
      logic wanted;
      if (owed_verdicts.size() == 0) begin
         $error("hostname_ok: expected none, actual %0d", actual);
         mismatches++;
         return;
      end
      wanted = owed_verdicts.pop_front();
      if (actual !== wanted) begin
         $error("hostname_ok: expected %0d, actual %0d", wanted, actual);
         mismatches++;
      end
   endfunction

   function int pending_count();
      return owed_verdicts.size();
   endfunction
endclass

module hostname_label_validator_top_tb;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CHAR_TARGET  = 1800;

   logic clock;
   logic reset;
   int   cycle_count;
   int   chars_sent;
   bit   req_idle_on;
   bit   rsp_idle_on;

   hostname_verdict_board verdicts;

   hlv_req_if req_bus ();
   hlv_rsp_if rsp_bus ();

   hostname_label_validator_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** hostname_label_validator_top: FAILED **");
         $finish;
      end
   end

   // One character transfer, with an optional idle gap before it
   task automatic send_char(input logic [7:0] code);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      verdicts.note_char(code);
      chars_sent++;
   endtask

   // A whole name followed by its terminator
   task automatic send_name(input char_list_type name);
      foreach (name[i]) send_char(name[i]);
      send_char(hlv_pkg::CHAR_END);
   endtask

   function automatic char_list_type from_text(input string s);
      char_list_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] random_alnum();
      int k;
      k = $urandom_range(0, 61);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 36) return 8'(8'h41 + (k - 10));
      return 8'(8'h61 + (k - 36));
   endfunction

   // Label of the given length; hyphens only inside
   function automatic char_list_type make_label(input int len);
      char_list_type q;
      for (int i = 0; i < len; i++) begin
         if (i > 0 && i < len - 1 && $urandom_range(0, 5) == 0)
            q.push_back(hlv_pkg::CHAR_HYPHEN);
         else
            q.push_back(random_alnum());
      end
      return q;
   endfunction

   function automatic char_list_type join_labels(input int lens[$]);
      char_list_type q;
      char_list_type lab;
      foreach (lens[i]) begin
         if (i > 0) q.push_back(hlv_pkg::CHAR_DOT);
         lab = make_label(lens[i]);
         foreach (lab[j]) q.push_back(lab[j]);
      end
      return q;
   endfunction

   // Mostly short labels, now and then one around the label limit
   function automatic char_list_type make_name();
      int lens[$];
      int count;
      count = $urandom_range(1, 4);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) lens.push_back($urandom_range(55, 70));
         else lens.push_back($urandom_range(1, 10));
      end
      return join_labels(lens);
   endfunction

   // Names near and past the overall limit
   function automatic char_list_type make_long_name();
      int lens[$];
      int count;
      count = $urandom_range(4, 5);
      repeat (count - 1) lens.push_back(63);
      lens.push_back($urandom_range(55, 66));
      return join_labels(lens);
   endfunction

   // Change a well-formed name in one spot, mostly so that it breaks
   function automatic char_list_type damage_name(input char_list_type q);
      int pos;
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 5))
         0: q[pos] = 8'($urandom_range(1, 255));
         1: q.push_front(hlv_pkg::CHAR_DOT);
         2: q.push_back(hlv_pkg::CHAR_DOT);
         3: q.push_back(hlv_pkg::CHAR_HYPHEN);
         4: q.push_front(hlv_pkg::CHAR_HYPHEN);
         default: begin
            q.insert(pos, hlv_pkg::CHAR_DOT);
            q.insert(pos, hlv_pkg::CHAR_DOT);
         end
      endcase
      return q;
   endfunction

   function automatic char_list_type make_noise();
      char_list_type q;
      int len;
      len = $urandom_range(0, 16);
      repeat (len) q.push_back(8'($urandom_range(1, 255)));
      return q;
   endfunction

   // Result side: random stall before each verdict transfer
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (taken % 16 == 0) rsp_idle_on = $urandom_range(0, 2) != 0;
         gap = rsp_idle_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         verdicts.check_verdict(rsp_bus.hostname_ok);
         taken++;
      end
   end

   // Stimulus
   initial begin
      char_list_type name;
      int names_done;
      verdicts          = new();
      cycle_count       = 0;
      chars_sent        = 0;
      req_idle_on       = 1'b1;
      rsp_idle_on       = 1'b1;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.char_code <= 8'h00;
      rsp_bus.ready     <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed names
      send_name(from_text(""));
      send_name(from_text("a"));
      send_name(from_text("09AZaz.host-1.x"));
      send_name(from_text(".a"));
      send_name(from_text("a."));
      send_name(from_text("a..b"));
      send_name(from_text("-a"));
      send_name(from_text("a-"));
      send_name(from_text("a--b"));
      send_name(from_text("a-.b"));
      send_name(from_text("a.-b"));
      send_name(from_text("/:@[`{ _"));
      send_name(from_text("_abc.def"));
      send_name('{8'h61, 8'h80, 8'h62});
      send_name('{8'hFF, 8'h7F, 8'h01});
      send_name(join_labels('{63}));
      send_name(join_labels('{64}));
      send_name(join_labels('{63, 63, 63, 61}));
      send_name(join_labels('{63, 63, 63, 62}));
      send_name(join_labels('{63, 63, 63, 63, 63}));
      send_name(join_labels('{100}));

      // Random names
      names_done = 0;
      while (chars_sent < CHAR_TARGET) begin
         if ($urandom_range(0, 2) == 0) req_idle_on = !req_idle_on;
         if (names_done % 40 == 39)
            name = make_long_name();
         else if ($urandom_range(0, 4) == 0)
            name = make_noise();
         else begin
            name = make_name();
            if ($urandom_range(0, 9) < 3) name = damage_name(name);
         end
         send_name(name);
         names_done++;
      end
      req_bus.valid <= 1'b0;

      // Drain
      while (verdicts.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts.mismatches == 0) begin
         $display("** hostname_label_validator_top: PASSED **");
      end else begin
         $display("** hostname_label_validator_top: FAILED **");
      end
      $finish;
   end
endmodule
